### design/lcg_pkg.sv
// Package for the label class grouper: sizes, action and status codes,
// and the command record passed from the front end to the back end.
// No dependencies.
package lcg_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_CLASSES = 16;
    localparam int SAMPLE_AW   = $clog2(MAX_SAMPLES);
    localparam int CLASS_AW    = $clog2(MAX_CLASSES);
    localparam int COUNT_W     = SAMPLE_AW + 1;
    localparam int CNUM_W      = CLASS_AW + 1;
    localparam int LABEL_W     = 32;
    localparam int ACTION_W    = 3;
    localparam int POS_W       = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RCLASS = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RPERM  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MANY  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam logic [LABEL_W-1:0] LABEL_NEG1 = 32'hFFFF_FFFF;
    localparam logic [LABEL_W-1:0] LABEL_POS1 = 32'h0000_0001;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LABEL_W-1:0]  label_value;
        logic [POS_W-1:0]    position;
    } cmd_t;

endpackage

### design/lcg_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module lcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### design/lcg_front.sv
// Front end: accepts items into a short command queue.
// Depends on lcg_pkg.
module lcg_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  lcg_pkg::cmd_t in_cmd,
    output logic          q_valid,
    output lcg_pkg::cmd_t q_cmd,
    input  logic          q_take
);
    lcg_pkg::cmd_t slot_reg [lcg_pkg::QUEUE_DEPTH];
    logic          rd_ptr_reg, wr_ptr_reg;
    logic [1:0]    fill_reg, fill_next;
    logic          push;

    assign in_stall = (fill_reg == 2'(lcg_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg + 2'(push) - 2'(q_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_take |-> q_valid)
        else $error("take from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 2'd2)
        else $error("queue overfill");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("pointer mismatch on empty");
endmodule

### design/lcg_back.sv
// Back end: class table, sample and permutation memories, finish sequencer,
// output register. Depends on lcg_pkg and lcg_ram.
module lcg_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  lcg_pkg::cmd_t                 q_cmd,
    output logic                          q_take,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [4:0]                    class_number,
    output logic signed [31:0]            class_label,
    output logic [10:0]                   class_count,
    output logic [10:0]                   class_start,
    output logic [9:0]                    sample_index
);
    localparam int NC = lcg_pkg::MAX_CLASSES;
    localparam int AW = lcg_pkg::SAMPLE_AW;
    localparam int CW = lcg_pkg::COUNT_W;
    localparam int KW = lcg_pkg::CLASS_AW;
    localparam int NW = lcg_pkg::CNUM_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWAP  = 3'd1;
    localparam logic [2:0] S_PREF  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_PERM  = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;

    logic [2:0]                  state_reg;
    logic [lcg_pkg::LABEL_W-1:0] lab_reg   [NC];
    logic [CW-1:0]               cnt_reg   [NC];
    logic [CW-1:0]               start_reg [NC];
    logic [CW-1:0]               nxt_reg   [NC];
    logic [CW-1:0]               total_reg;
    logic [NW-1:0]               seen_reg;
    logic                        done_reg;
    logic                        swap_reg;
    logic [CW-1:0]               idx_reg;
    logic [CW-1:0]               acc_reg;
    logic [KW:0]                 k_reg;

    logic                        ovalid_reg, ovalid_next;
    logic [1:0]                  st_reg, st_next;
    logic [4:0]                  cn_reg, cn_next;
    logic [31:0]                 cl_reg, cl_next;
    logic [10:0]                 cc_reg, cs_reg, cc_next, cs_next;
    logic [9:0]                  si_reg, si_next;

    logic          sc_we, pm_we;
    logic [AW-1:0] sc_addr, pm_addr;
    logic [KW-1:0] sc_wdata, sc_rdata;
    logic [AW-1:0] pm_wdata, pm_rdata;

    lcg_ram #(.WIDTH(KW), .DEPTH(lcg_pkg::MAX_SAMPLES)) u_sc (
        .clk(clk), .we(sc_we), .addr(sc_addr), .wdata(sc_wdata), .rdata(sc_rdata));
    lcg_ram #(.WIDTH(AW), .DEPTH(lcg_pkg::MAX_SAMPLES)) u_pm (
        .clk(clk), .we(pm_we), .addr(pm_addr), .wdata(pm_wdata), .rdata(pm_rdata));

    logic          hit;
    logic [KW-1:0] hit_k;
    logic          out_free;
    logic          start_cmd;

    always_comb
    begin
        hit   = 1'b0;
        hit_k = '0;
        for (int k = NC - 1; k >= 0; k--)
        begin
            if (NW'(k) < seen_reg && lab_reg[k] == q_cmd.label_value)
            begin
                hit   = 1'b1;
                hit_k = KW'(k);
            end
        end
    end

    assign out_free  = !ovalid_reg || !out_stall;
    assign start_cmd = (state_reg == S_IDLE) && q_valid && out_free;
    assign q_take    = start_cmd;

    logic [KW-1:0] scan_cls;
    assign scan_cls = swap_reg ? KW'(sc_rdata == '0) : sc_rdata;

    always_comb
    begin
        sc_we    = 1'b0;
        sc_addr  = idx_reg[AW-1:0];
        sc_wdata = '0;
        pm_we    = 1'b0;
        pm_addr  = q_cmd.position[AW-1:0];
        pm_wdata = AW'(idx_reg - CW'(1));
        if (start_cmd && q_cmd.action == lcg_pkg::ACT_APPEND && !done_reg
            && total_reg < CW'(lcg_pkg::MAX_SAMPLES) && (hit || seen_reg < NW'(NC)))
        begin
            sc_we    = 1'b1;
            sc_addr  = total_reg[AW-1:0];
            sc_wdata = hit ? hit_k : seen_reg[KW-1:0];
        end
        if (state_reg == S_PERM)
        begin
            pm_we    = 1'b1;
            pm_addr  = nxt_reg[scan_cls][AW-1:0];
            sc_we    = swap_reg;
            sc_addr  = AW'(idx_reg - CW'(1));
            sc_wdata = scan_cls;
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg && out_stall;
        st_next     = st_reg;
        cn_next     = cn_reg;
        cl_next     = cl_reg;
        cc_next     = cc_reg;
        cs_next     = cs_reg;
        si_next     = si_reg;
        if (start_cmd)
        begin
            st_next = lcg_pkg::ST_OK;
            cn_next = '0;
            cl_next = '0;
            cc_next = '0;
            cs_next = '0;
            si_next = '0;
            unique case (q_cmd.action)
                lcg_pkg::ACT_APPEND:
                begin
                    ovalid_next = 1'b1;
                    priority if (done_reg)
                        st_next = lcg_pkg::ST_BAD;
                    else if (total_reg >= CW'(lcg_pkg::MAX_SAMPLES))
                        st_next = lcg_pkg::ST_FULL;
                    else if (hit)
                        cn_next = 5'(hit_k);
                    else if (seen_reg >= NW'(NC))
                        st_next = lcg_pkg::ST_MANY;
                    else
                        cn_next = 5'(seen_reg);
                end
                lcg_pkg::ACT_FINISH:
                begin
                    ovalid_next = 1'b0;
                end
                lcg_pkg::ACT_RCLASS:
                begin
                    ovalid_next = 1'b1;
                    if (!done_reg || 11'(q_cmd.position) >= 11'(seen_reg))
                        st_next = lcg_pkg::ST_BAD;
                    else
                    begin
                        cl_next = lab_reg[q_cmd.position[KW-1:0]];
                        cc_next = 11'(cnt_reg[q_cmd.position[KW-1:0]]);
                        cs_next = 11'(start_reg[q_cmd.position[KW-1:0]]);
                    end
                end
                lcg_pkg::ACT_RPERM:
                begin
                    if (!done_reg || 11'(q_cmd.position) >= 11'(total_reg))
                    begin
                        st_next     = lcg_pkg::ST_BAD;
                        ovalid_next = 1'b1;
                    end
                end
                lcg_pkg::ACT_CLEAR:
                begin
                    ovalid_next = 1'b1;
                end
                default:
                begin
                    ovalid_next = 1'b1;
                    st_next     = lcg_pkg::ST_BAD;
                end
            endcase
        end
        if (state_reg == S_SCAN && idx_reg >= total_reg)
        begin
            ovalid_next = 1'b1;
            st_next     = lcg_pkg::ST_OK;
            cn_next     = 5'(seen_reg);
        end
        if (state_reg == S_READ)
        begin
            ovalid_next = 1'b1;
            si_next     = 10'(pm_rdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            st_reg     <= '0;
            cn_reg     <= '0;
            cl_reg     <= '0;
            cc_reg     <= '0;
            cs_reg     <= '0;
            si_reg     <= '0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            st_reg     <= st_next;
            cn_reg     <= cn_next;
            cl_reg     <= cl_next;
            cc_reg     <= cc_next;
            cs_reg     <= cs_next;
            si_reg     <= si_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            seen_reg   <= '0;
            done_reg   <= 1'b0;
            swap_reg   <= 1'b0;
            idx_reg    <= '0;
            acc_reg    <= '0;
            k_reg      <= '0;
            for (int k = 0; k < NC; k++)
            begin
                lab_reg[k]   <= '0;
                cnt_reg[k]   <= '0;
                start_reg[k] <= '0;
                nxt_reg[k]   <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start_cmd)
                    begin
                        unique case (q_cmd.action)
                            lcg_pkg::ACT_APPEND:
                            begin
                                if (!done_reg && total_reg < CW'(lcg_pkg::MAX_SAMPLES))
                                begin
                                    if (hit)
                                    begin
                                        cnt_reg[hit_k] <= cnt_reg[hit_k] + CW'(1);
                                        total_reg      <= total_reg + CW'(1);
                                    end
                                    else if (seen_reg < NW'(NC))
                                    begin
                                        lab_reg[seen_reg[KW-1:0]] <= q_cmd.label_value;
                                        cnt_reg[seen_reg[KW-1:0]] <= CW'(1);
                                        seen_reg  <= seen_reg + NW'(1);
                                        total_reg <= total_reg + CW'(1);
                                    end
                                end
                            end
                            lcg_pkg::ACT_FINISH:
                            begin
                                swap_reg <= (seen_reg == NW'(2))
                                    && lab_reg[0] == lcg_pkg::LABEL_NEG1
                                    && lab_reg[1] == lcg_pkg::LABEL_POS1;
                                idx_reg  <= '0;
                                state_reg <= S_SWAP;
                            end
                            lcg_pkg::ACT_RPERM:
                            begin
                                if (done_reg && 11'(q_cmd.position) < 11'(total_reg))
                                    state_reg <= S_READ;
                            end
                            lcg_pkg::ACT_CLEAR:
                            begin
                                total_reg  <= '0;
                                seen_reg   <= '0;
                                done_reg   <= 1'b0;
                                for (int k = 0; k < NC; k++)
                                begin
                                    lab_reg[k]   <= '0;
                                    cnt_reg[k]   <= '0;
                                    start_reg[k] <= '0;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SWAP:
                begin
                    if (swap_reg)
                    begin
                        lab_reg[0] <= lab_reg[1];
                        lab_reg[1] <= lab_reg[0];
                        cnt_reg[0] <= cnt_reg[1];
                        cnt_reg[1] <= cnt_reg[0];
                    end
                    k_reg   <= '0;
                    acc_reg <= '0;
                    state_reg <= S_PREF;
                end
                S_PREF:
                begin
                    if (k_reg[KW-1:0] == KW'(NC - 1) || (KW+1)'(k_reg) >= (KW+1)'(seen_reg)
                        || k_reg[KW])
                    begin
                        if (!k_reg[KW] && (KW+1)'(k_reg) < (KW+1)'(seen_reg))
                        begin
                            start_reg[k_reg[KW-1:0]] <= acc_reg;
                            nxt_reg[k_reg[KW-1:0]]   <= acc_reg;
                        end
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        start_reg[k_reg[KW-1:0]] <= acc_reg;
                        nxt_reg[k_reg[KW-1:0]]   <= acc_reg;
                        acc_reg <= acc_reg + cnt_reg[k_reg[KW-1:0]];
                        k_reg   <= k_reg + (KW+1)'(1);
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg >= total_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_PERM;
                    end
                end
                S_PERM:
                begin
                    nxt_reg[scan_cls] <= nxt_reg[scan_cls] + CW'(1);
                    state_reg <= S_SCAN;
                end
                S_READ:
                begin
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = ovalid_reg;
    assign status       = st_reg;
    assign class_number = cn_reg;
    assign class_label  = cl_reg;
    assign class_count  = cc_reg;
    assign class_start  = cs_reg;
    assign sample_index = si_reg;

    assert property (@(posedge clk) disable iff (!rst_n) total_reg <= CW'(lcg_pkg::MAX_SAMPLES))
        else $error("sample total overflow");
    assert property (@(posedge clk) disable iff (!rst_n) seen_reg <= NW'(NC))
        else $error("class count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) q_take |-> state_reg == S_IDLE)
        else $error("take while busy");
endmodule

### design/label_class_grouper_unit.sv
// Label class grouper: appends labels, groups samples by class, serves reads.
// Append, class read, clear: result held in a queue slot, then the output register;
// one item per cycle while out_stall is low and no finish or permutation read runs.
// Permutation read adds a RAM read. Finish does one sample-class RAM read and one
// permutation write per sample. rst_n is asynchronous, active low, and empties the
// class table and queue. Depends on lcg_pkg, lcg_front, lcg_back.
module label_class_grouper_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic signed [31:0] label_value,
    input  logic [9:0]         position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [4:0]         class_number,
    output logic signed [31:0] class_label,
    output logic [10:0]        class_count,
    output logic [10:0]        class_start,
    output logic [9:0]         sample_index
);
    lcg_pkg::cmd_t in_cmd, q_cmd;
    logic          q_valid, q_take;

    assign in_cmd.action      = action;
    assign in_cmd.label_value = label_value;
    assign in_cmd.position    = position;

    lcg_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take));

    lcg_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .class_number(class_number), .class_label(class_label),
        .class_count(class_count), .class_start(class_start),
        .sample_index(sample_index));
endmodule
